// ===== hw/rtl/rcsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Rover command safety interlock package
// Shared types and protocol codes for the interlock and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsi_pkg;

  // Serial protocol byte codes.
  localparam logic [7:0] CODE_HELLO     = 8'hD1;
  localparam logic [7:0] CODE_ACK       = 8'hD2;
  localparam logic [7:0] CODE_FORWARD   = 8'hE1;
  localparam logic [7:0] CODE_BACKWARD  = 8'hE2;
  localparam logic [7:0] CODE_LEFT      = 8'hE3;
  localparam logic [7:0] CODE_RIGHT     = 8'hE4;
  localparam logic [7:0] CODE_STOP      = 8'hE0;
  localparam logic [7:0] CODE_DATA      = 8'hFD;
  localparam logic [7:0] CODE_BRAKE_EN  = 8'hFB;
  localparam logic [7:0] CODE_BRAKE_DIS = 8'hFC;
  localparam logic [7:0] CODE_STOP_EN   = 8'hFA;
  localparam logic [7:0] CODE_STOP_DIS  = 8'hFE;

  // Configuration register map.
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CFG_BRAKE_DIST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE   = 2'd1;

  // Register reset values.
  localparam logic [9:0]  BRAKE_DIST_RST = 10'd50;
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;

  // Maximum number of results one item produces.
  localparam int unsigned MaxRes = 3;
  localparam int unsigned ResCntW = 2;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_DIST   = 2'd1,
    ACT_BUTTON = 2'd2,
    ACT_NONE   = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    MOT_FORWARD  = 3'd0,
    MOT_BACKWARD = 3'd1,
    MOT_LEFT     = 3'd2,
    MOT_RIGHT    = 3'd3,
    MOT_STOP     = 3'd4
  } motor_e;

  typedef struct packed {
    action_e     action;
    logic [7:0]  rx_byte;
    logic [9:0]  distance_cm;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       motor_valid;
    motor_e     motor_cmd;
    logic       estop_led;
    logic       last;
  } out_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rover_command_safety_interlock.sv =====
// ----------------------------------------------------------------------------
// Rover command safety interlock
// Host handshake, motor command gating, emergency stop and auto-braking.
// ----------------------------------------------------------------------------
// Usage:
//   Input items (serial byte, distance reading or button press) arrive on
//   in_valid_i / in_stall_o / in_data_i; a transfer happens when valid is
//   high and stall is low. Result items leave on out_valid_o / out_stall_i /
//   out_data_o under the same rule, one result per transfer, with last set
//   on the final result of an item. Configuration writes use cfg_valid_i /
//   cfg_ready_o with a register index and data, and are taken at any time.
//   Flow: an item is registered on acceptance, then decoded from the input
//   register into a three-entry result buffer once that buffer is free, and
//   its first result is offered from the buffer. An item may be accepted in
//   every cycle while in_stall_o is low; the result buffer drains one result
//   per cycle while out_stall_i is low, and the next item is loaded as the
//   final result of the last one transfers. Items that yield no result
//   leave the buffer free.
//   When the receiver stalls, the buffer and the input register hold and
//   in_stall_o rises once the input register is occupied.
//   Reset clears the handshake, emergency stop, braking and last press time
//   and loads both configuration registers with 50.
// ----------------------------------------------------------------------------
`default_nettype none

module rover_command_safety_interlock
  import rcsi_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers.
  logic [9:0]  brake_dist_q;
  logic [15:0] debounce_q;

  // Control state.
  logic        hs_done_q, hs_done_d;
  logic        estop_q, estop_d;
  logic        braking_q, braking_d;
  logic [31:0] last_press_q, last_press_d;

  // Input register.
  logic        in_vld_q;
  in_item_t    in_q;

  // Result buffer.
  out_item_t            buf_q [MaxRes];
  logic [ResCntW-1:0]   buf_cnt_q;
  logic [ResCntW-1:0]   buf_idx_q;

  // Decode results.
  out_item_t            res   [MaxRes];
  logic [ResCntW-1:0]   res_cnt;

  logic buf_done;
  logic buf_free;
  logic load;
  logic out_xfer;
  logic [31:0] gap;
  logic [7:0]  half;

  // Configuration port is always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brake_dist_q <= BRAKE_DIST_RST;
      debounce_q   <= DEBOUNCE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BRAKE_DIST: brake_dist_q <= cfg_data_i[9:0];
        CFG_DEBOUNCE:   debounce_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake between the input register, result buffer and output.
  assign out_valid_o = (buf_cnt_q != '0);
  assign out_xfer    = out_valid_o && !out_stall_i;
  assign buf_done    = out_xfer && (buf_idx_q == buf_cnt_q - 2'd1);
  assign buf_free    = (buf_cnt_q == '0) || buf_done;
  assign load        = in_vld_q && buf_free;
  assign in_stall_o  = in_vld_q && !buf_free;
  assign out_data_o  = buf_q[buf_idx_q];

  // Input register takes a new item whenever it is empty or moving on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  assign gap  = in_q.now_ms - last_press_q;
  assign half = in_q.distance_cm[9] ? 8'hFF : in_q.distance_cm[8:1];

  // Decode one item into its results and the next control state.
  always_comb begin
    hs_done_d    = hs_done_q;
    estop_d      = estop_q;
    braking_d    = braking_q;
    last_press_d = last_press_q;
    res_cnt      = '0;
    for (int k = 0; k < MaxRes; k++) begin
      res[k] = '{tx_valid: 1'b0, tx_byte: 8'h00, motor_valid: 1'b0,
                 motor_cmd: MOT_FORWARD, estop_led: 1'b0, last: 1'b0};
    end

    unique case (in_q.action)
      ACT_BYTE: begin
        if (!hs_done_q) begin
          if (in_q.rx_byte == CODE_HELLO) begin
            hs_done_d        = 1'b1;
            res[0].tx_valid  = 1'b1;
            res[0].tx_byte   = CODE_ACK;
            res_cnt          = 2'd1;
          end
        end else if (!estop_q) begin
          res[0].motor_valid = 1'b1;
          res_cnt            = 2'd1;
          unique case (in_q.rx_byte)
            CODE_FORWARD: begin
              res[0].motor_cmd = MOT_FORWARD;
              if (braking_q) begin
                res_cnt = 2'd0;
              end
            end
            CODE_BACKWARD: res[0].motor_cmd = MOT_BACKWARD;
            CODE_LEFT:     res[0].motor_cmd = MOT_LEFT;
            CODE_RIGHT:    res[0].motor_cmd = MOT_RIGHT;
            CODE_STOP:     res[0].motor_cmd = MOT_STOP;
            default:       res_cnt = 2'd0;
          endcase
        end
      end
      ACT_DIST: begin
        if (hs_done_q) begin
          res[0].tx_valid = 1'b1;
          res[0].tx_byte  = CODE_DATA;
          res[1].tx_valid = 1'b1;
          res[1].tx_byte  = half;
          res_cnt         = 2'd2;
          if (in_q.distance_cm <= brake_dist_q) begin
            braking_d          = 1'b1;
            res[2].tx_valid    = 1'b1;
            res[2].tx_byte     = CODE_BRAKE_EN;
            res[2].motor_valid = !braking_q;
            res[2].motor_cmd   = braking_q ? MOT_FORWARD : MOT_STOP;
            res_cnt            = 2'd3;
          end else if (braking_q) begin
            braking_d       = 1'b0;
            res[2].tx_valid = 1'b1;
            res[2].tx_byte  = CODE_BRAKE_DIS;
            res_cnt         = 2'd3;
          end
        end
      end
      ACT_BUTTON: begin
        if (gap >= {16'h0000, debounce_q}) begin
          estop_d         = !estop_q;
          last_press_d    = in_q.now_ms;
          res[0].tx_valid = 1'b1;
          res_cnt         = 2'd1;
          if (!estop_q) begin
            res[0].tx_byte     = CODE_STOP_EN;
            res[0].motor_valid = 1'b1;
            res[0].motor_cmd   = MOT_STOP;
          end else begin
            res[0].tx_byte = CODE_STOP_DIS;
          end
        end
      end
      ACT_NONE: ;
      default: ;
    endcase

    // The LED level is common to every result; the last flag marks the final one.
    for (int k = 0; k < MaxRes; k++) begin
      res[k].estop_led = estop_d;
      res[k].last      = (ResCntW'(k) + 2'd1 == res_cnt);
    end
  end

  // Control state advances when the decoded item is loaded.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hs_done_q    <= 1'b0;
      estop_q      <= 1'b0;
      braking_q    <= 1'b0;
      last_press_q <= '0;
    end else if (load) begin
      hs_done_q    <= hs_done_d;
      estop_q      <= estop_d;
      braking_q    <= braking_d;
      last_press_q <= last_press_d;
    end
  end

  // Result buffer count and read index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_cnt_q <= '0;
      buf_idx_q <= '0;
    end else if (load) begin
      buf_cnt_q <= res_cnt;
      buf_idx_q <= '0;
    end else if (buf_done) begin
      buf_cnt_q <= '0;
      buf_idx_q <= '0;
    end else if (out_xfer) begin
      buf_idx_q <= buf_idx_q + 2'd1;
    end
  end

  // Result payloads.
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int k = 0; k < MaxRes; k++) begin
        buf_q[k] <= res[k];
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rcsi_checker.sv =====
// ----------------------------------------------------------------------------
// Rover command safety interlock checker
// Port-level properties of the interlock, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsi_checker
  import rcsi_pkg::*;
(
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      out_valid_i,
  input wire logic      out_stall_i,
  input wire out_item_t out_data_i
);

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // A byte that is not sent reads as zero.
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.tx_valid |-> out_data_i.tx_byte == 8'h00)
    else $error("unsent tx byte is not zero");

  // A motor command that is not applied reads as zero.
  a_motor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_data_i.motor_valid |-> out_data_i.motor_cmd == MOT_FORWARD)
    else $error("unapplied motor command is not zero");

  // Enabling the emergency stop lights the LED and stops the motors.
  a_stop_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.tx_valid && out_data_i.tx_byte == CODE_STOP_EN
    |-> out_data_i.estop_led && out_data_i.motor_valid &&
        out_data_i.motor_cmd == MOT_STOP)
    else $error("emergency stop enable without LED or stop command");

endmodule

bind rover_command_safety_interlock rcsi_checker u_rcsi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

`default_nettype wire
